// ===== rtl/xtea_pkg.sv =====
// Shared types, constants and helper functions for the XTEA cipher pipeline.
// Depends on nothing; used by xtea_block_cipher_core.
package xtea_pkg;

  typedef logic [31:0] word_t;
  typedef logic [2:0] reg_index_t;
  typedef logic [1:0] key_sel_t;

  localparam int CYCLE_COUNT = 32;
  localparam int STAGE_COUNT = 2 * CYCLE_COUNT;
  localparam word_t DELTA = 32'h9E37_79B9;

  localparam reg_index_t REG_KEY_ZERO  = 3'd0;
  localparam reg_index_t REG_KEY_ONE   = 3'd1;
  localparam reg_index_t REG_KEY_TWO   = 3'd2;
  localparam reg_index_t REG_KEY_THREE = 3'd3;

  function automatic word_t mix_word(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Running sum seen by a given half-round stage. Encryption counts up from
  // zero, decryption counts down from delta times the cycle count.
  function automatic word_t stage_sum(input int stage, input logic decrypt);
    int round;
    int count;
    round = stage >> 1;
    if (!decrypt) begin
      count = ((stage & 1) == 0) ? round : round + 1;
    end else begin
      count = ((stage & 1) == 0) ? CYCLE_COUNT - round : CYCLE_COUNT - round - 1;
    end
    return DELTA * word_t'(count);
  endfunction

  // Key word picked by the sum: low bits or bits 12:11.
  function automatic key_sel_t key_index(input word_t sum, input logic use_high);
    return use_high ? sum[12:11] : sum[1:0];
  endfunction

endpackage

// ===== rtl/xtea_block_cipher_core.sv =====
// XTEA block cipher core: a fully unrolled half-round pipeline.
// Depends on xtea_pkg for types, round constants and the mix function.

// How to use this block:
// The key is four 32-bit words written through write_enable, reg_index and
// write_data; a write takes effect at the clock edge where write_enable is
// high, and indexes beyond three are ignored. Keys are cleared by reset and
// must only be changed while no word is in flight.
// A word (operation plus the two block halves) is taken at every rising edge
// where start is high and busy is low. operation low encrypts, high decrypts.
// Each stage of the pipeline does one half of a Feistel cycle, so there are
// 64 stages plus an input register. A word accepted at one edge passes
// through the input register and every stage register, then appears on
// result_first_word and result_second_word, with done high, for one cycle.
// Outside reset, one word per cycle is sustained: the rate is set by the single half-round
// adder chain in each stage.
// The receiver cannot stall; every result is shown exactly once.
// Reset (rst, synchronous) empties the pipeline and clears the key. busy is
// high while rst is held, and otherwise stays low.
module xtea_block_cipher_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation,
  input  xtea_pkg::word_t       block_first_word,
  input  xtea_pkg::word_t       block_second_word,
  output logic                  done,
  output xtea_pkg::word_t       result_first_word,
  output xtea_pkg::word_t       result_second_word,
  input  logic                  write_enable,
  input  xtea_pkg::reg_index_t  reg_index,
  input  xtea_pkg::word_t       write_data
);

  // Key registers, read only at fixed places by each stage.
  xtea_pkg::word_t key_word [0:3];

  // Pipeline registers: index 0 is the input register, the last one the
  // output register. The operation bit rides along with the data.
  logic            stage_valid [0:xtea_pkg::STAGE_COUNT];
  logic            stage_op    [0:xtea_pkg::STAGE_COUNT];
  xtea_pkg::word_t stage_a     [0:xtea_pkg::STAGE_COUNT];
  xtea_pkg::word_t stage_b     [0:xtea_pkg::STAGE_COUNT];

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // Key write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
    end else if (write_enable) begin
      case (reg_index)
        xtea_pkg::REG_KEY_ZERO:  key_word[0] <= write_data;
        xtea_pkg::REG_KEY_ONE:   key_word[1] <= write_data;
        xtea_pkg::REG_KEY_TWO:   key_word[2] <= write_data;
        xtea_pkg::REG_KEY_THREE: key_word[3] <= write_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op[0] <= operation;
      stage_a[0]  <= block_first_word;
      stage_b[0]  <= block_second_word;
    end
  end

  // One half-round per stage. In the first half of an encryption cycle the
  // y word is updated from z; in the first half of a decryption cycle z is
  // updated from y, so the source word flips with the operation bit.
  for (genvar s = 0; s < xtea_pkg::STAGE_COUNT; s++) begin : g_stage
    localparam logic HALF = (s % 2) == 1;
    localparam xtea_pkg::word_t ENC_SUM = xtea_pkg::stage_sum(s, 1'b0);
    localparam xtea_pkg::word_t DEC_SUM = xtea_pkg::stage_sum(s, 1'b1);
    localparam xtea_pkg::key_sel_t ENC_KEY = xtea_pkg::key_index(ENC_SUM, HALF);
    localparam xtea_pkg::key_sel_t DEC_KEY = xtea_pkg::key_index(DEC_SUM, !HALF);

    logic            src_is_a;
    xtea_pkg::word_t src_word;
    xtea_pkg::word_t round_key;
    xtea_pkg::word_t round_sum;
    xtea_pkg::word_t term;
    xtea_pkg::word_t a_next;
    xtea_pkg::word_t b_next;

    always_comb begin
      src_is_a  = stage_op[s] ^ HALF;
      src_word  = src_is_a ? stage_a[s] : stage_b[s];
      round_key = stage_op[s] ? key_word[DEC_KEY] : key_word[ENC_KEY];
      round_sum = stage_op[s] ? DEC_SUM : ENC_SUM;
      term      = xtea_pkg::mix_word(src_word) ^ (round_sum + round_key);
      a_next    = stage_a[s];
      b_next    = stage_b[s];
      if (src_is_a) begin
        b_next = stage_op[s] ? stage_b[s] - term : stage_b[s] + term;
      end else begin
        a_next = stage_op[s] ? stage_a[s] - term : stage_a[s] + term;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[s+1] <= 1'b0;
      end else begin
        stage_valid[s+1] <= stage_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      stage_op[s+1] <= stage_op[s];
      stage_a[s+1]  <= a_next;
      stage_b[s+1]  <= b_next;
    end
  end

  assign done               = stage_valid[xtea_pkg::STAGE_COUNT];
  assign result_first_word  = stage_a[xtea_pkg::STAGE_COUNT];
  assign result_second_word = stage_b[xtea_pkg::STAGE_COUNT];

`ifndef SYNTHESIS
  // Every accepted word comes out after the full pipeline depth.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(xtea_pkg::STAGE_COUNT + 1) done)
    else $error("accepted word did not come out on time");

  // No result without a matching accept.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, xtea_pkg::STAGE_COUNT + 1))
    else $error("result without a matching accepted word");

  // A result is never shown while reset is held or just after it.
  assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule

// ===== tb/xtea_block_cipher_core_tb.sv =====
// Self-checking testbench for the XTEA block cipher core: it drives block words and
// key writes, predicts each result with its own cipher model and checks it in order.
// Depends on xtea_pkg and xtea_block_cipher_core.
module xtea_block_cipher_core_tb;

  // Values of the operation bit.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Cycles without any accepted word, result or key write before the run is
  // declared hung. This is ample time for the pipeline to drain.
  localparam int WATCHDOG_LIMIT = 2000;
  // Depth of the core: input register plus 64 half-round stages.
  localparam int PIPE_LATENCY = 65;

  // One block as it goes in, paired with the ciphertext or plaintext that
  // must come out for it.
  typedef struct {
    logic            op;
    xtea_pkg::word_t in_first;
    xtea_pkg::word_t in_second;
    xtea_pkg::word_t out_first;
    xtea_pkg::word_t out_second;
  } cipher_job_t;

  // Keeps a private copy of the key and the in-order list of blocks that
  // are still in the pipeline.
  class cipher_scoreboard;
    xtea_pkg::word_t key [4];
    cipher_job_t     in_flight_q [$];
    int              errors;

    function new();
      foreach (key[i]) key[i] = '0;
      errors = 0;
    endfunction

    // Indexes above the last key word are dropped, just as the core does.
    function void write_reg(xtea_pkg::reg_index_t idx, xtea_pkg::word_t data);
      if (idx <= xtea_pkg::REG_KEY_THREE) key[idx[1:0]] = data;
    endfunction

    // Full XTEA on one block under the current key, running every Feistel cycle.
    function cipher_job_t run_cipher(logic op, xtea_pkg::word_t y, xtea_pkg::word_t z);
      cipher_job_t job;
      xtea_pkg::word_t a;
      xtea_pkg::word_t b;
      xtea_pkg::word_t sum;
      int n;
      a = y;
      b = z;
      if (op == OP_ENCRYPT) begin
        sum = '0;
        for (n = 0; n < xtea_pkg::CYCLE_COUNT; n++) begin
          a = a + ((((b << 4) ^ (b >> 5)) + b) ^ (sum + key[sum[1:0]]));
          sum = sum + xtea_pkg::DELTA;
          b = b + ((((a << 4) ^ (a >> 5)) + a) ^ (sum + key[sum[12:11]]));
        end
      end else begin
        // Decryption walks the cycles backwards from delta times the count.
        sum = xtea_pkg::DELTA * xtea_pkg::word_t'(xtea_pkg::CYCLE_COUNT);
        for (n = 0; n < xtea_pkg::CYCLE_COUNT; n++) begin
          b = b - ((((a << 4) ^ (a >> 5)) + a) ^ (sum + key[sum[12:11]]));
          sum = sum - xtea_pkg::DELTA;
          a = a - ((((b << 4) ^ (b >> 5)) + b) ^ (sum + key[sum[1:0]]));
        end
      end
      job.op = op;
      job.in_first = y;
      job.in_second = z;
      job.out_first = a;
      job.out_second = b;
      return job;
    endfunction

    function void note_block(logic op, xtea_pkg::word_t y, xtea_pkg::word_t z);
      in_flight_q.push_back(run_cipher(op, y, z));
    endfunction

    function void check_result(xtea_pkg::word_t first, xtea_pkg::word_t second);
      cipher_job_t job;
      if (in_flight_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: got %h %h", $time, first, second);
        errors++;
        return;
      end
      job = in_flight_q.pop_front();
      if (first !== job.out_first) begin
        $display("%0t: first word mismatch (op %0b, in %h %h): expected %h, got %h",
                 $time, job.op, job.in_first, job.in_second, job.out_first, first);
        errors++;
      end
      if (second !== job.out_second) begin
        $display("%0t: second word mismatch (op %0b, in %h %h): expected %h, got %h",
                 $time, job.op, job.in_first, job.in_second, job.out_second, second);
        errors++;
      end
    endfunction

    function int pending();
      return in_flight_q.size();
    endfunction
  endclass

  // Every input of the core starts at a known value; rst is high from time 0.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 operation = OP_ENCRYPT;
  xtea_pkg::word_t      block_first_word = '0;
  xtea_pkg::word_t      block_second_word = '0;
  logic                 done;
  xtea_pkg::word_t      result_first_word;
  xtea_pkg::word_t      result_second_word;
  logic                 write_enable = 1'b0;
  xtea_pkg::reg_index_t reg_index = xtea_pkg::REG_KEY_ZERO;
  xtea_pkg::word_t      write_data = '0;

  cipher_scoreboard sb = new();
  int               idle_cycles = 0;
  bit               progress;

  xtea_block_cipher_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .operation         (operation),
    .block_first_word  (block_first_word),
    .block_second_word (block_second_word),
    .done              (done),
    .result_first_word (result_first_word),
    .result_second_word(result_second_word),
    .write_enable      (write_enable),
    .reg_index         (reg_index),
    .write_data        (write_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Monitor. It samples at the rising edge, so it sees the values that the
  // core itself samples there: key writes, accepted words and the single
  // cycle result strobe. It also runs the hang watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (write_enable) begin
        sb.write_reg(reg_index, write_data);
        progress = 1'b1;
      end
      if (start && !busy) begin
        sb.note_block(operation, block_first_word, block_second_word);
        progress = 1'b1;
      end
      if (done) begin
        sb.check_result(result_first_word, result_second_word);
        progress = 1'b1;
      end
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Mostly uniform words, with zero, all ones and single set bits thrown in
  // often enough to hit the carry and shift corners of the round function.
  function automatic xtea_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return xtea_pkg::word_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Offers one word and returns at the edge where it is taken. busy only
  // moves on a rising edge, so the value seen at the falling edge before it
  // tells whether that edge will accept the word. The optional gap drops
  // start before the word is offered.
  task automatic send_block(logic op, xtea_pkg::word_t y, xtea_pkg::word_t z,
                            bit allow_idle);
    if (allow_idle && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 35);
    end
    start <= 1'b1;
    operation <= op;
    block_first_word <= y;
    block_second_word <= z;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  // Stops offering words and waits until every result has come back. The
  // key may only change with the pipeline empty, so this precedes each
  // key load; the extra wait after it is a margin on top of the drain.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Loads all four key words on back-to-back edges, with one write to an
  // unused index mixed in at a random slot; the core must ignore that one.
  task automatic load_key(xtea_pkg::word_t k0, xtea_pkg::word_t k1,
                          xtea_pkg::word_t k2, xtea_pkg::word_t k3);
    xtea_pkg::word_t words [4];
    int              junk_slot;
    int              next_key;
    int              s;
    words = '{k0, k1, k2, k3};
    junk_slot = $urandom_range(0, 4);
    next_key = 0;
    for (s = 0; s < 5; s++) begin
      write_enable <= 1'b1;
      if (s == junk_slot) begin
        reg_index <= xtea_pkg::reg_index_t'(xtea_pkg::REG_KEY_THREE + 1 +
                                            $urandom_range(0, 3));
        write_data <= $urandom;
      end else begin
        reg_index <= xtea_pkg::reg_index_t'(next_key);
        write_data <= words[next_key];
        next_key++;
      end
      @(posedge clk);
    end
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // Each corner word is paired with its mirror in the list, once per
  // operation, so both halves see every extreme.
  task automatic send_corners();
    xtea_pkg::word_t corner [6];
    int i;
    corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
               32'h8000_0000, 32'h0000_0001};
    for (i = 0; i < 6; i++) begin
      send_block(OP_ENCRYPT, corner[i], corner[5 - i], 1'b0);
      send_block(OP_DECRYPT, corner[i], corner[5 - i], 1'b0);
    end
  endtask

  task automatic send_random(int count, bit allow_idle);
    int i;
    for (i = 0; i < count; i++) begin
      send_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT,
                 pick_word(), pick_word(), allow_idle);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: corner blocks under the all-zero key left by reset,
    // then under the all-ones key.
    send_corners();
    drain_pipeline();
    load_key('1, '1, '1, '1);
    send_corners();
    drain_pipeline();

    // Random part, one key per phase. The third phase runs with start held
    // high throughout, so the pipeline is kept completely full.
    load_key($urandom, $urandom, $urandom, $urandom);
    send_random(250, 1'b1);
    drain_pipeline();
    load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_random(200, 1'b1);
    drain_pipeline();
    load_key($urandom, $urandom, $urandom, $urandom);
    send_random(300, 1'b0);
    drain_pipeline();
    load_key('0, '0, '0, '0);
    send_random(150, 1'b1);
    drain_pipeline();
    load_key($urandom, $urandom, $urandom, $urandom);
    send_random(300, 1'b1);
    drain_pipeline();

    // Anything that shows up now has no block behind it and is flagged by
    // the monitor; a result that never arrives trips the watchdog instead.
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
